/* rtl/swst_pkg.sv */
// Package: types and constants for the sorted weekly schedule table.
package swst_pkg;

    localparam int DEFAULT_DEPTH = 64;
    localparam int ENTRY_W = 17;
    localparam int KEY_W = 14;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_FIND   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] dispenser;
        logic [2:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] index;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] entry_count;
        logic [5:0] next_index;
        logic [2:0] read_dispenser;
        logic [2:0] read_day;
        logic [4:0] read_hour;
        logic [5:0] read_minute;
        logic [7:0] dispenser_mask;
    } rsp_t;

endpackage

/* rtl/swst_req_if.sv */
// Interface: request channel.
interface swst_req_if
    import swst_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/swst_rsp_if.sv */
// Interface: response channel.
interface swst_rsp_if
    import swst_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/sorted_weekly_schedule_table_unit.sv */
// Top level: sorted weekly schedule table with sequencer over one synchronous memory.
// Usage:
//   req channel takes one request (operation, dispenser, day, hour, minute, index).
//   rsp channel returns exactly one response per request, in order.
//   One request is handled at a time; req.ready is high only when the sequencer is
//   idle and the response register is empty.
//   Operation steps, n = entries held: clear, full insert and unused codes go
//   straight to the response; read does one memory read; find scans up to n entries;
//   insert scans for the slot, then shifts the tail up one entry at a time
//   (a read, then a write); remove reads each entry and writes each kept
//   entry to its compacted position. Each entry visit costs one memory read.
//   Throughput: the next request is taken the cycle after the response is delivered.
//   Reset empties the table (count, due position and mask cleared); memory
//   contents are not cleared and never read beyond the count.
//   A stalled response holds in its register; no new request is taken until it
//   is delivered.
module sorted_weekly_schedule_table_unit
    import swst_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    swst_req_if.sink req,
    swst_rsp_if.source rsp
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_REM, S_READ, S_DONE}
        state_t;

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;
    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;

    state_t        state_reg;
    req_t          cmd_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] ptr_reg;
    logic [CW-1:0] kept_reg;
    logic [CW-1:0] pos_reg;
    logic          pend_reg;
    logic [5:0]    due_reg;
    logic [7:0]    mask_reg;
    logic [1:0]    st_reg;
    logic [ENTRY_W-1:0] rd_entry_reg;
    logic          out_valid_reg;
    rsp_t          out_reg;

    logic [KEY_W-1:0] cur_key;
    logic [ENTRY_W-1:0] cur_entry;
    assign cur_key = {cmd_reg.day, cmd_reg.hour, cmd_reg.minute};
    assign cur_entry = {cmd_reg.dispenser, cur_key};

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data = out_reg;

    // memory access control
    always_comb
    begin
        we = 1'b0;
        re = 1'b0;
        waddr = '0;
        raddr = ptr_reg[AW-1:0];
        wdata = rdata_reg;
        case (state_reg)
            S_SCAN:
            begin
                re = (ptr_reg < count_reg);
            end
            S_SHIFT_RD:
            begin
                re = (ptr_reg > pos_reg);
                raddr = AW'(ptr_reg - 1'b1);
                if (ptr_reg == pos_reg)
                begin
                    we = 1'b1;
                    waddr = pos_reg[AW-1:0];
                    wdata = cur_entry;
                end
            end
            S_SHIFT_WR:
            begin
                we = 1'b1;
                waddr = ptr_reg[AW-1:0];
            end
            S_REM:
            begin
                re = (ptr_reg < count_reg);
                if (pend_reg && rdata_reg[ENTRY_W-1:KEY_W] != cmd_reg.dispenser)
                begin
                    we = 1'b1;
                    waddr = kept_reg[AW-1:0];
                end
            end
            S_READ:
            begin
                re = !pend_reg;
                raddr = AW'(cmd_reg.index);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            due_reg <= '0;
            mask_reg <= '0;
            out_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        cmd_reg <= req.data;
                        ptr_reg <= '0;
                        kept_reg <= '0;
                        pend_reg <= 1'b0;
                        st_reg <= ST_OK;
                        rd_entry_reg <= '0;
                        state_reg <= S_DONE;
                        case (req.data.operation)
                            OP_INSERT:
                            begin
                                if (count_reg >= CW'(TABLE_DEPTH))
                                begin
                                    st_reg <= ST_FULL;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            OP_REMOVE:
                            begin
                                mask_reg <= mask_reg & ~(8'h1 << req.data.dispenser);
                                state_reg <= S_REM;
                            end
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                                mask_reg <= '0;
                                due_reg <= '0;
                            end
                            OP_FIND:
                            begin
                                state_reg <= S_SCAN;
                            end
                            OP_READ:
                            begin
                                if (32'(req.data.index) < 32'(count_reg)
                                    && 32'(req.data.index) < TABLE_DEPTH)
                                begin
                                    state_reg <= S_READ;
                                end
                                else
                                begin
                                    st_reg <= ST_RANGE;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    // pend_reg: rdata_reg holds entry ptr_reg-1
                    if (pend_reg && rdata_reg[KEY_W-1:0] >
                        (cmd_reg.operation == OP_FIND ? cur_key : cur_key))
                    begin
                        if (cmd_reg.operation == OP_FIND)
                        begin
                            due_reg <= 6'(ptr_reg - 1'b1);
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            pos_reg <= ptr_reg - 1'b1;
                            ptr_reg <= count_reg;
                            state_reg <= S_SHIFT_RD;
                        end
                        pend_reg <= 1'b0;
                    end
                    else if (ptr_reg >= count_reg)
                    begin
                        pend_reg <= 1'b0;
                        if (cmd_reg.operation == OP_FIND)
                        begin
                            due_reg <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            pos_reg <= count_reg;
                            ptr_reg <= count_reg;
                            state_reg <= S_SHIFT_RD;
                        end
                    end
                    else
                    begin
                        pend_reg <= 1'b1;
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                S_SHIFT_RD:
                begin
                    if (ptr_reg == pos_reg)
                    begin
                        count_reg <= count_reg + 1'b1;
                        mask_reg <= mask_reg | (8'h1 << cmd_reg.dispenser);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR:
                begin
                    ptr_reg <= ptr_reg - 1'b1;
                    state_reg <= S_SHIFT_RD;
                end
                S_REM:
                begin
                    if (pend_reg && rdata_reg[ENTRY_W-1:KEY_W] != cmd_reg.dispenser)
                    begin
                        kept_reg <= kept_reg + 1'b1;
                    end
                    if (ptr_reg >= count_reg)
                    begin
                        count_reg <= (pend_reg && rdata_reg[ENTRY_W-1:KEY_W]
                                      != cmd_reg.dispenser) ? kept_reg + 1'b1 : kept_reg;
                        pend_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        pend_reg <= 1'b1;
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                S_READ:
                begin
                    if (pend_reg)
                    begin
                        rd_entry_reg <= rdata_reg;
                        pend_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        pend_reg <= 1'b1;
                    end
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    out_reg.status <= st_reg;
                    out_reg.entry_count <= 7'(count_reg);
                    out_reg.next_index <= due_reg;
                    out_reg.read_dispenser <= rd_entry_reg[16:14];
                    out_reg.read_day <= rd_entry_reg[13:11];
                    out_reg.read_hour <= rd_entry_reg[10:6];
                    out_reg.read_minute <= rd_entry_reg[5:0];
                    out_reg.dispenser_mask <= mask_reg;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(TABLE_DEPTH))
        else $error("count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !rsp.valid)
        else $error("response before request done");
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> state_reg == S_IDLE)
        else $error("busy while response pending");
endmodule
